@@ design/dsih_pkg.sv @@
// Package for the iterated substitution hash: the DES S-box S1 table and the
// round function shared by the pipeline stages. No dependencies.
package dsih_pkg;

   localparam int unsigned ROUND_COUNT_DEFAULT = 16;
   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned GROUP_COUNT = 8;

   typedef logic [WORD_WIDTH-1:0] word_type;

   localparam logic [3:0] S1_TABLE [4][16] = '{
      '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7},
      '{4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
        4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8},
      '{4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
        4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0},
      '{4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
        4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13}
   };

   // One round. The expansion is pure wiring: group g sees word bits
   // 4g-1 up to 4g+4, wrapping round the ends of the word, so a copy of
   // the word with one wrapped bit on each side supplies every group.
   function automatic word_type sbox_round(input word_type w);
      logic [WORD_WIDTH+1:0] ext;
      logic [5:0]            six;
      word_type              res;
      ext = {w[0], w, w[WORD_WIDTH-1]};
      res = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         six = ext[4*g +: 6];
         res[4*g +: 4] = S1_TABLE[{six[5], six[0]}][six[4:1]];
      end
      return res;
   endfunction

endpackage

@@ design/des_sbox_iterated_hash32.sv @@
// Iterated substitution hash: one pipeline stage per round.
// Throughput: one word per cycle while rsp_ready is high; each stage
// holds one word and moves it on when the stage after it is empty or
// emptying, so bubbles close up.
// Reset (synchronous, active high) clears every stage valid bit; data
// registers are not reset.
module des_sbox_iterated_hash32 #(
   parameter int unsigned ROUND_COUNT = dsih_pkg::ROUND_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_block_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest,
   output logic [31:0] rsp_first_round_word
);

   logic                 valid_ff [ROUND_COUNT];
   dsih_pkg::word_type   word_ff  [ROUND_COUNT];
   dsih_pkg::word_type   first_ff [ROUND_COUNT];
   logic                 ready    [ROUND_COUNT+1];

   assign ready[ROUND_COUNT] = rsp_ready;
   assign req_ready = ready[0];

   for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_stage
      logic               up_valid;
      dsih_pkg::word_type word_in;
      dsih_pkg::word_type first_in;

      assign ready[k] = !valid_ff[k] || ready[k+1];

      if (k == 0) begin : g_head
         assign up_valid = req_valid;
         assign word_in  = dsih_pkg::sbox_round(req_block_in);
         assign first_in = word_in;
      end else begin : g_body
         assign up_valid = valid_ff[k-1];
         assign word_in  = dsih_pkg::sbox_round(word_ff[k-1]);
         assign first_in = first_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= up_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k] && up_valid) begin
            word_ff[k]  <= word_in;
            first_ff[k] <= first_in;
         end
      end
   end

   assign rsp_valid            = valid_ff[ROUND_COUNT-1];
   assign rsp_digest           = word_ff[ROUND_COUNT-1];
   assign rsp_first_round_word = first_ff[ROUND_COUNT-1];

endmodule

@@ design/dsih_checker.sv @@
// Port-level checks for the iterated substitution hash, bound to the top
// level. Depends on des_sbox_iterated_hash32 only through its ports.
module dsih_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [31:0] req_block_in,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest,
   input logic [31:0] rsp_first_round_word
);

   // Nothing can come out in the cycle straight after reset.
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown straight after reset");

   // With the output stage empty the whole pipeline can move, so the input
   // must be open.
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input closed while the output stage is empty");

   // A request word that is held off stays offered and unchanged.
   a_req_hold : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_block_in))
      else $error("stalled request word changed or vanished");

   // A stalled result word holds.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest)
         && $stable(rsp_first_round_word))
      else $error("stalled result word changed or vanished");

endmodule

bind des_sbox_iterated_hash32 dsih_checker u_dsih_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .req_block_in         (req_block_in),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_digest           (rsp_digest),
   .rsp_first_round_word (rsp_first_round_word)
);
